// ===== sv/cldq_pkg.sv =====
// Shared types, codes and command/status bundles for the circular list engine.
package cldq_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DEL_AFTER  = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;
  localparam logic [2:0] OP_READ_OUT   = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [4:0] {
    S_SWEEP,
    S_CLEAR,
    S_IDLE,
    S_PUSH_A,
    S_PUSH_B,
    S_PUSH_C,
    S_PUSH_D,
    S_POPF_A,
    S_POPF_B,
    S_POPF_C,
    S_POPF_D,
    S_POPB_A,
    S_POPB_B,
    S_POPB_W,
    S_POPB_FIX,
    S_POPB_GIVE,
    S_DEL_A,
    S_DEL_B,
    S_DEL_W,
    S_DEL_LINK,
    S_DEL_GIVE,
    S_RD_A,
    S_RD_B,
    S_RD_EMIT,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {RA_CUR, RA_TAIL, RA_FREE, RA_LRD} raddr_sel_t;
  typedef enum logic [2:0] {WA_CUR, WA_TAIL, WA_PTR, WA_HOLD, WA_SWEEP} waddr_sel_t;
  typedef enum logic [2:0] {WD_CUR, WD_LRD, WD_FREE, WD_HOLD, WD_SWEEP} wdata_sel_t;
  typedef enum logic [2:0] {FR_KEEP, FR_LRD, FR_CUR, FR_TAIL, FR_HOLD, FR_ZERO} free_sel_t;
  typedef enum logic [1:0] {TL_KEEP, TL_CUR, TL_PTR, TL_ZERO} tail_sel_t;
  typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_DEC, CNT_ZERO} cnt_sel_t;
  typedef enum logic [1:0] {CUR_KEEP, CUR_FREE, CUR_LRD} cur_sel_t;
  typedef enum logic [1:0] {OUT_NONE, OUT_STATUS, OUT_ITEM} out_sel_t;

  typedef struct packed {
    logic       operand_load;
    raddr_sel_t rd_addr;
    logic       link_we;
    waddr_sel_t wr_addr;
    wdata_sel_t wr_data;
    logic       val_we;
    free_sel_t  free_sel;
    tail_sel_t  tail_sel;
    cnt_sel_t   cnt_sel;
    cur_sel_t   cur_sel;
    logic       ptr_load;
    logic       hold_load;
    logic       step_clr;
    logic       step_inc;
    logic       sweep_inc;
    out_sel_t   out_sel;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic count_full;
    logic walk_last;
    logic back_reached;
    logic match;
    logic d_is_tail;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/cldq_ctrl.sv =====
// Sequencing state machine that steps each list operation through the datapath.
module cldq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        op_code,
  input  cldq_pkg::stat_t   stat,
  output cldq_pkg::cmd_t    cmd
);

  cldq_pkg::state_t state, state_next;
  logic             back, back_next;
  logic [1:0]       resp, resp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cldq_pkg::S_SWEEP;
      back  <= 1'b0;
      resp  <= cldq_pkg::ST_OK;
    end else begin
      state <= state_next;
      back  <= back_next;
      resp  <= resp_next;
    end
  end

  always_comb begin
    state_next = state;
    back_next  = back;
    resp_next  = resp;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      cldq_pkg::S_SWEEP, cldq_pkg::S_CLEAR: begin
        cmd.link_we   = 1'b1;
        cmd.wr_addr   = cldq_pkg::WA_SWEEP;
        cmd.wr_data   = cldq_pkg::WD_SWEEP;
        cmd.sweep_inc = 1'b1;
        if (stat.sweep_last) begin
          cmd.free_sel = cldq_pkg::FR_ZERO;
          cmd.tail_sel = cldq_pkg::TL_ZERO;
          cmd.cnt_sel  = cldq_pkg::CNT_ZERO;
          state_next   = (state == cldq_pkg::S_CLEAR) ? cldq_pkg::S_RESP : cldq_pkg::S_IDLE;
        end
      end
      cldq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.operand_load = 1'b1;
          resp_next        = cldq_pkg::ST_OK;
          unique case (op_code)
            cldq_pkg::OP_PUSH_FRONT, cldq_pkg::OP_PUSH_BACK: begin
              back_next = (op_code == cldq_pkg::OP_PUSH_BACK);
              if (stat.count_full) begin
                resp_next  = cldq_pkg::ST_FULL;
                state_next = cldq_pkg::S_RESP;
              end else begin
                state_next = cldq_pkg::S_PUSH_A;
              end
            end
            cldq_pkg::OP_POP_FRONT: begin
              if (stat.count_zero) begin
                resp_next  = cldq_pkg::ST_EMPTY;
                state_next = cldq_pkg::S_RESP;
              end else begin
                state_next = cldq_pkg::S_POPF_A;
              end
            end
            cldq_pkg::OP_POP_BACK: begin
              if (stat.count_zero) begin
                resp_next  = cldq_pkg::ST_EMPTY;
                state_next = cldq_pkg::S_RESP;
              end else if (stat.count_one) begin
                state_next = cldq_pkg::S_POPB_GIVE;
              end else begin
                state_next = cldq_pkg::S_POPB_A;
              end
            end
            cldq_pkg::OP_DEL_AFTER: begin
              if (stat.count_zero) begin
                resp_next  = cldq_pkg::ST_EMPTY;
                state_next = cldq_pkg::S_RESP;
              end else begin
                state_next = cldq_pkg::S_DEL_A;
              end
            end
            cldq_pkg::OP_CLEAR: begin
              if (stat.count_zero) begin
                resp_next  = cldq_pkg::ST_EMPTY;
                state_next = cldq_pkg::S_RESP;
              end else begin
                state_next = cldq_pkg::S_CLEAR;
              end
            end
            cldq_pkg::OP_READ_OUT: begin
              if (stat.count_zero) begin
                resp_next  = cldq_pkg::ST_EMPTY;
                state_next = cldq_pkg::S_RESP;
              end else begin
                state_next = cldq_pkg::S_RD_A;
              end
            end
            default: begin
              state_next = cldq_pkg::S_RESP;
            end
          endcase
        end
      end
      cldq_pkg::S_PUSH_A: begin
        cmd.rd_addr = cldq_pkg::RA_FREE;
        cmd.val_we  = 1'b1;
        cmd.cur_sel = cldq_pkg::CUR_FREE;
        state_next  = cldq_pkg::S_PUSH_B;
      end
      cldq_pkg::S_PUSH_B: begin
        cmd.free_sel = cldq_pkg::FR_LRD;
        if (stat.count_zero) begin
          cmd.link_we  = 1'b1;
          cmd.wr_addr  = cldq_pkg::WA_CUR;
          cmd.wr_data  = cldq_pkg::WD_CUR;
          cmd.tail_sel = cldq_pkg::TL_CUR;
          cmd.cnt_sel  = cldq_pkg::CNT_INC;
          state_next   = cldq_pkg::S_RESP;
        end else begin
          cmd.rd_addr = cldq_pkg::RA_TAIL;
          state_next  = cldq_pkg::S_PUSH_C;
        end
      end
      cldq_pkg::S_PUSH_C: begin
        cmd.link_we = 1'b1;
        cmd.wr_addr = cldq_pkg::WA_CUR;
        cmd.wr_data = cldq_pkg::WD_LRD;
        state_next  = cldq_pkg::S_PUSH_D;
      end
      cldq_pkg::S_PUSH_D: begin
        cmd.link_we = 1'b1;
        cmd.wr_addr = cldq_pkg::WA_TAIL;
        cmd.wr_data = cldq_pkg::WD_CUR;
        cmd.cnt_sel = cldq_pkg::CNT_INC;
        if (back) begin
          cmd.tail_sel = cldq_pkg::TL_CUR;
        end
        state_next = cldq_pkg::S_RESP;
      end
      cldq_pkg::S_POPF_A: begin
        cmd.rd_addr = cldq_pkg::RA_TAIL;
        state_next  = cldq_pkg::S_POPF_B;
      end
      cldq_pkg::S_POPF_B: begin
        cmd.cur_sel = cldq_pkg::CUR_LRD;
        cmd.rd_addr = cldq_pkg::RA_LRD;
        state_next  = cldq_pkg::S_POPF_C;
      end
      cldq_pkg::S_POPF_C: begin
        if (!stat.count_one) begin
          cmd.link_we = 1'b1;
          cmd.wr_addr = cldq_pkg::WA_TAIL;
          cmd.wr_data = cldq_pkg::WD_LRD;
        end
        state_next = cldq_pkg::S_POPF_D;
      end
      cldq_pkg::S_POPF_D: begin
        cmd.link_we  = 1'b1;
        cmd.wr_addr  = cldq_pkg::WA_CUR;
        cmd.wr_data  = cldq_pkg::WD_FREE;
        cmd.free_sel = cldq_pkg::FR_CUR;
        cmd.cnt_sel  = cldq_pkg::CNT_DEC;
        state_next   = cldq_pkg::S_RESP;
      end
      cldq_pkg::S_POPB_A: begin
        cmd.rd_addr = cldq_pkg::RA_TAIL;
        state_next  = cldq_pkg::S_POPB_B;
      end
      cldq_pkg::S_POPB_B: begin
        cmd.ptr_load  = 1'b1;
        cmd.hold_load = 1'b1;
        cmd.step_clr  = 1'b1;
        cmd.rd_addr   = cldq_pkg::RA_LRD;
        state_next    = cldq_pkg::S_POPB_W;
      end
      cldq_pkg::S_POPB_W: begin
        if (stat.back_reached) begin
          state_next = cldq_pkg::S_POPB_FIX;
        end else begin
          cmd.ptr_load = 1'b1;
          cmd.step_inc = 1'b1;
          cmd.rd_addr  = cldq_pkg::RA_LRD;
        end
      end
      cldq_pkg::S_POPB_FIX: begin
        cmd.link_we = 1'b1;
        cmd.wr_addr = cldq_pkg::WA_PTR;
        cmd.wr_data = cldq_pkg::WD_HOLD;
        state_next  = cldq_pkg::S_POPB_GIVE;
      end
      cldq_pkg::S_POPB_GIVE: begin
        cmd.link_we  = 1'b1;
        cmd.wr_addr  = cldq_pkg::WA_TAIL;
        cmd.wr_data  = cldq_pkg::WD_FREE;
        cmd.free_sel = cldq_pkg::FR_TAIL;
        cmd.cnt_sel  = cldq_pkg::CNT_DEC;
        cmd.tail_sel = stat.count_one ? cldq_pkg::TL_KEEP : cldq_pkg::TL_PTR;
        state_next   = cldq_pkg::S_RESP;
      end
      cldq_pkg::S_DEL_A: begin
        cmd.rd_addr = cldq_pkg::RA_TAIL;
        state_next  = cldq_pkg::S_DEL_B;
      end
      cldq_pkg::S_DEL_B: begin
        cmd.cur_sel  = cldq_pkg::CUR_LRD;
        cmd.step_clr = 1'b1;
        cmd.rd_addr  = cldq_pkg::RA_LRD;
        state_next   = cldq_pkg::S_DEL_W;
      end
      cldq_pkg::S_DEL_W: begin
        if (stat.match) begin
          cmd.hold_load = 1'b1;
          if (stat.d_is_tail) begin
            cmd.tail_sel = cldq_pkg::TL_CUR;
          end
          if (stat.count_one) begin
            state_next = cldq_pkg::S_DEL_GIVE;
          end else begin
            cmd.rd_addr = cldq_pkg::RA_LRD;
            state_next  = cldq_pkg::S_DEL_LINK;
          end
        end else if (stat.walk_last) begin
          resp_next  = cldq_pkg::ST_NOTFOUND;
          state_next = cldq_pkg::S_RESP;
        end else begin
          cmd.cur_sel  = cldq_pkg::CUR_LRD;
          cmd.step_inc = 1'b1;
          cmd.rd_addr  = cldq_pkg::RA_LRD;
        end
      end
      cldq_pkg::S_DEL_LINK: begin
        cmd.link_we = 1'b1;
        cmd.wr_addr = cldq_pkg::WA_CUR;
        cmd.wr_data = cldq_pkg::WD_LRD;
        state_next  = cldq_pkg::S_DEL_GIVE;
      end
      cldq_pkg::S_DEL_GIVE: begin
        cmd.link_we  = 1'b1;
        cmd.wr_addr  = cldq_pkg::WA_HOLD;
        cmd.wr_data  = cldq_pkg::WD_FREE;
        cmd.free_sel = cldq_pkg::FR_HOLD;
        cmd.cnt_sel  = cldq_pkg::CNT_DEC;
        state_next   = cldq_pkg::S_RESP;
      end
      cldq_pkg::S_RD_A: begin
        cmd.rd_addr = cldq_pkg::RA_TAIL;
        state_next  = cldq_pkg::S_RD_B;
      end
      cldq_pkg::S_RD_B: begin
        cmd.cur_sel  = cldq_pkg::CUR_LRD;
        cmd.step_clr = 1'b1;
        cmd.rd_addr  = cldq_pkg::RA_LRD;
        state_next   = cldq_pkg::S_RD_EMIT;
      end
      cldq_pkg::S_RD_EMIT: begin
        if (stat.out_free) begin
          cmd.out_sel = cldq_pkg::OUT_ITEM;
          if (stat.walk_last) begin
            state_next = cldq_pkg::S_IDLE;
          end else begin
            cmd.cur_sel  = cldq_pkg::CUR_LRD;
            cmd.step_inc = 1'b1;
            cmd.rd_addr  = cldq_pkg::RA_LRD;
          end
        end else begin
          cmd.rd_addr = cldq_pkg::RA_CUR;
        end
      end
      cldq_pkg::S_RESP: begin
        if (stat.out_free) begin
          cmd.out_sel = cldq_pkg::OUT_STATUS;
          cmd.status  = resp;
          state_next  = cldq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cldq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/cldq_datapath.sv =====
// Node store, list pointers, walk counters and the output register.
module cldq_datapath #(
  parameter int CAPACITY    = cldq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = cldq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cldq_pkg::cmd_t                      cmd,
  output cldq_pkg::stat_t                     stat,
  input  logic signed [VALUE_WIDTH-1:0]       operand_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic signed [VALUE_WIDTH-1:0]       item_value,
  output logic                                run_end,
  output logic [$clog2(CAPACITY+1)-1:0]       entry_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [IW-1:0]          lmem [CAPACITY];
  logic [VALUE_WIDTH-1:0] vmem [CAPACITY];

  logic [IW-1:0]          lrd;
  logic [VALUE_WIDTH-1:0] vrd;
  logic [IW-1:0]          tail;
  logic [IW-1:0]          free_head;
  logic [IW-1:0]          cur;
  logic [IW-1:0]          ptr;
  logic [IW-1:0]          hold;
  logic [IW-1:0]          sweep;
  logic [IW-1:0]          sweep_next;
  logic [CW-1:0]          count;
  logic [CW-1:0]          step;
  logic [VALUE_WIDTH-1:0] operand;

  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic [IW-1:0] wdata;

  assign sweep_next = stat.sweep_last ? '0 : sweep + 1'b1;

  always_comb begin
    unique case (cmd.rd_addr)
      cldq_pkg::RA_CUR:  raddr = cur;
      cldq_pkg::RA_TAIL: raddr = tail;
      cldq_pkg::RA_FREE: raddr = free_head;
      cldq_pkg::RA_LRD:  raddr = lrd;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_addr)
      cldq_pkg::WA_CUR:   waddr = cur;
      cldq_pkg::WA_TAIL:  waddr = tail;
      cldq_pkg::WA_PTR:   waddr = ptr;
      cldq_pkg::WA_HOLD:  waddr = hold;
      cldq_pkg::WA_SWEEP: waddr = sweep;
      default:            waddr = cur;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_data)
      cldq_pkg::WD_CUR:   wdata = cur;
      cldq_pkg::WD_LRD:   wdata = lrd;
      cldq_pkg::WD_FREE:  wdata = free_head;
      cldq_pkg::WD_HOLD:  wdata = hold;
      cldq_pkg::WD_SWEEP: wdata = sweep_next;
      default:            wdata = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.link_we) begin
      lmem[waddr] <= wdata;
    end
    if (cmd.val_we) begin
      vmem[free_head] <= operand;
    end
    lrd <= lmem[raddr];
    vrd <= vmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail      <= '0;
      free_head <= '0;
      count     <= '0;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (cmd.free_sel)
        cldq_pkg::FR_KEEP: free_head <= free_head;
        cldq_pkg::FR_LRD:  free_head <= lrd;
        cldq_pkg::FR_CUR:  free_head <= cur;
        cldq_pkg::FR_TAIL: free_head <= tail;
        cldq_pkg::FR_HOLD: free_head <= hold;
        cldq_pkg::FR_ZERO: free_head <= '0;
        default:           free_head <= free_head;
      endcase
      unique case (cmd.tail_sel)
        cldq_pkg::TL_KEEP: tail <= tail;
        cldq_pkg::TL_CUR:  tail <= cur;
        cldq_pkg::TL_PTR:  tail <= ptr;
        cldq_pkg::TL_ZERO: tail <= '0;
      endcase
      unique case (cmd.cnt_sel)
        cldq_pkg::CNT_KEEP: count <= count;
        cldq_pkg::CNT_INC:  count <= count + 1'b1;
        cldq_pkg::CNT_DEC:  count <= count - 1'b1;
        cldq_pkg::CNT_ZERO: count <= '0;
      endcase
      if (cmd.sweep_inc) begin
        sweep <= sweep_next;
      end
      if (cmd.out_sel != cldq_pkg::OUT_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.operand_load) begin
      operand <= operand_value;
    end
    unique case (cmd.cur_sel)
      cldq_pkg::CUR_KEEP: cur <= cur;
      cldq_pkg::CUR_FREE: cur <= free_head;
      cldq_pkg::CUR_LRD:  cur <= lrd;
      default:            cur <= cur;
    endcase
    if (cmd.ptr_load) begin
      ptr <= lrd;
    end
    if (cmd.hold_load) begin
      hold <= lrd;
    end
    if (cmd.step_clr) begin
      step <= '0;
    end else if (cmd.step_inc) begin
      step <= step + 1'b1;
    end
    unique case (cmd.out_sel)
      cldq_pkg::OUT_NONE: begin
      end
      cldq_pkg::OUT_STATUS: begin
        status      <= cmd.status;
        item_value  <= '0;
        run_end     <= 1'b1;
        entry_count <= count;
      end
      cldq_pkg::OUT_ITEM: begin
        status      <= cldq_pkg::ST_OK;
        item_value  <= vrd;
        run_end     <= stat.walk_last;
        entry_count <= count;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.count_zero   = (count == '0);
    stat.count_one    = (count == CW'(1));
    stat.count_full   = (count == CW'(CAPACITY));
    stat.walk_last    = ((step + CW'(1)) == count);
    stat.back_reached = ((step + CW'(2)) == count);
    stat.match        = (vrd == operand);
    stat.d_is_tail    = (lrd == tail);
    stat.sweep_last   = (sweep == IW'(CAPACITY - 1));
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

// ===== sv/circular_list_deque_engine_unit.sv =====
// Top level of the circular linked list engine: controller, datapath and checks.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    op_code, operand_value
//   out      output     out_valid / out_ready  status, item_value, run_end, entry_count
//
// One operation is worked at a time. Pop back, delete after match and read out walk the list
// one link per cycle, since the link store has one read port; read out also waits while the
// output register is full. Clear sweeps over every entry of the link store.
// After reset a pass over the link store rebuilds the free chain with in_ready low.
// A result waits in the output register while the next operation is taken.
module circular_list_deque_engine_unit #(
  parameter int CAPACITY    = cldq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = cldq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        op_code,
  input  logic signed [VALUE_WIDTH-1:0]     operand_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [VALUE_WIDTH-1:0]     item_value,
  output logic                              run_end,
  output logic [$clog2(CAPACITY+1)-1:0]     entry_count
);

  cldq_pkg::cmd_t  cmd;
  cldq_pkg::stat_t stat;

  cldq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op_code  (op_code),
    .stat     (stat),
    .cmd      (cmd)
  );

  cldq_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operand_value (operand_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .item_value    (item_value),
    .run_end       (run_end),
    .entry_count   (entry_count)
  );

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    !(stat.count_full && cmd.cnt_sel == cldq_pkg::CNT_INC))
    else $error("element count grew past capacity");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_sel != cldq_pkg::OUT_NONE |-> !in_ready)
    else $error("result loaded while a new operation could be taken");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_sel != cldq_pkg::OUT_NONE |=> out_valid)
    else $error("loaded result did not appear on the output");

  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cldq_pkg::ST_OK |-> run_end)
    else $error("error status beat not marked as the final beat");

endmodule

// ===== sim/circular_list_deque_engine_unit_test.sv =====
// Self-checking testbench for the circular list engine: queued random and directed traffic.
module circular_list_deque_engine_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 16;
  localparam int VW  = 32;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int N_RANDOM = 400;
  localparam int SEG_LEN  = 40;

  typedef struct packed {
    logic [1:0]    st;
    logic [VW-1:0] val;
    logic          fin;
    logic [4:0]    cnt;
  } beat_t;

  typedef struct {
    logic [2:0]    op;
    logic [VW-1:0] val;
    bit            drain;
  } list_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           op_code = '0;
  logic signed [VW-1:0] operand_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic signed [VW-1:0] item_value;
  logic                 run_end;
  logic [4:0]           entry_count;

  list_cmd_t pending_cmds[$];
  beat_t     due_beats[$];
  int        errors = 0;
  int        items_in = 0;
  int        burst_left = 1;
  int        gap_left = 0;
  int        hold_left = 0;
  int        pattern_left = 0;
  int        pattern_mode = 0;
  bit        long_hold_done = 1'b0;
  beat_t     got_beat;

  logic [VW-1:0] mem_val [CAP];
  logic [3:0]    mem_link [CAP];
  logic [3:0]    tail_p;
  logic [3:0]    free_p;
  int            n_elems;

  circular_list_deque_engine_unit #(
    .CAPACITY(CAP),
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op_code(op_code),
    .operand_value(operand_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .item_value(item_value),
    .run_end(run_end),
    .entry_count(entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void rebuild_chain();
    for (int i = 0; i < CAP; i++) mem_link[i] = (i + 1 < CAP) ? 4'(i + 1) : 4'd0;
    tail_p = '0;
    free_p = '0;
    n_elems = 0;
  endfunction

  function automatic logic [3:0] take_node();
    logic [3:0] n;
    n = free_p;
    free_p = mem_link[n];
    return n;
  endfunction

  function automatic void give_node(logic [3:0] n);
    mem_link[n] = free_p;
    free_p = n;
  endfunction

  function automatic logic [1:0] push_value(logic [VW-1:0] v, bit at_back);
    logic [3:0] n;
    if (n_elems >= CAP) return cldq_pkg::ST_FULL;
    n = take_node();
    mem_val[n] = v;
    if (n_elems == 0) begin
      mem_link[n] = n;
      tail_p = n;
    end else begin
      mem_link[n] = mem_link[tail_p];
      mem_link[tail_p] = n;
      if (at_back) tail_p = n;
    end
    n_elems++;
    return cldq_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] pop_head();
    logic [3:0] h;
    if (n_elems == 0) return cldq_pkg::ST_EMPTY;
    h = mem_link[tail_p];
    if (n_elems != 1) mem_link[tail_p] = mem_link[h];
    give_node(h);
    n_elems--;
    return cldq_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] pop_tail();
    logic [3:0] p;
    if (n_elems == 0) return cldq_pkg::ST_EMPTY;
    if (n_elems == 1) begin
      give_node(tail_p);
      n_elems = 0;
      return cldq_pkg::ST_OK;
    end
    p = mem_link[tail_p];
    for (int i = 0; i + 2 < n_elems; i++) p = mem_link[p];
    mem_link[p] = mem_link[tail_p];
    give_node(tail_p);
    tail_p = p;
    n_elems--;
    return cldq_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] unlink_after(logic [VW-1:0] v);
    logic [3:0] c;
    logic [3:0] d;
    if (n_elems == 0) return cldq_pkg::ST_EMPTY;
    c = mem_link[tail_p];
    for (int i = 0; i < n_elems; i++) begin
      if (mem_val[c] == v) begin
        d = mem_link[c];
        if (n_elems == 1) begin
          give_node(d);
          n_elems = 0;
          return cldq_pkg::ST_OK;
        end
        if (d == tail_p) tail_p = c;
        mem_link[c] = mem_link[d];
        give_node(d);
        n_elems--;
        return cldq_pkg::ST_OK;
      end
      c = mem_link[c];
    end
    return cldq_pkg::ST_NOTFOUND;
  endfunction

  function automatic void note_beat(logic [1:0] st, logic [VW-1:0] v, logic fin);
    beat_t b;
    b.st  = st;
    b.val = v;
    b.fin = fin;
    b.cnt = 5'(n_elems);
    due_beats.push_back(b);
  endfunction

  function automatic void list_apply(logic [2:0] op, logic [VW-1:0] v);
    logic [1:0] st;
    logic [3:0] c;
    st = cldq_pkg::ST_OK;
    case (op)
      cldq_pkg::OP_PUSH_FRONT: st = push_value(v, 1'b0);
      cldq_pkg::OP_PUSH_BACK:  st = push_value(v, 1'b1);
      cldq_pkg::OP_POP_FRONT:  st = pop_head();
      cldq_pkg::OP_POP_BACK:   st = pop_tail();
      cldq_pkg::OP_DEL_AFTER:  st = unlink_after(v);
      cldq_pkg::OP_CLEAR: begin
        if (n_elems == 0) st = cldq_pkg::ST_EMPTY;
        else rebuild_chain();
      end
      cldq_pkg::OP_READ_OUT: begin
        if (n_elems == 0) begin
          note_beat(cldq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          c = mem_link[tail_p];
          for (int i = 0; i < n_elems; i++) begin
            note_beat(cldq_pkg::ST_OK, mem_val[c], (i + 1 == n_elems));
            c = mem_link[c];
          end
        end
        return;
      end
      default: st = cldq_pkg::ST_OK;
    endcase
    note_beat(st, '0, 1'b1);
  endfunction

  function automatic void add_cmd(logic [2:0] op, logic [VW-1:0] v, bit drain);
    list_cmd_t c;
    c.op = op;
    c.val = v;
    c.drain = drain;
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [VW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5, 6: return VW'($urandom_range(1, 7));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_op(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      0: begin
        if (r < 40) return cldq_pkg::OP_PUSH_FRONT;
        if (r < 75) return cldq_pkg::OP_PUSH_BACK;
        if (r < 83) return cldq_pkg::OP_READ_OUT;
        if (r < 90) return cldq_pkg::OP_DEL_AFTER;
        if (r < 95) return cldq_pkg::OP_POP_FRONT;
        if (r < 98) return cldq_pkg::OP_POP_BACK;
        if (r < 99) return cldq_pkg::OP_CLEAR;
        return OP_UNUSED;
      end
      1: begin
        if (r < 12) return cldq_pkg::OP_PUSH_FRONT;
        if (r < 24) return cldq_pkg::OP_PUSH_BACK;
        if (r < 34) return cldq_pkg::OP_READ_OUT;
        if (r < 56) return cldq_pkg::OP_DEL_AFTER;
        if (r < 75) return cldq_pkg::OP_POP_FRONT;
        if (r < 95) return cldq_pkg::OP_POP_BACK;
        if (r < 97) return cldq_pkg::OP_CLEAR;
        return OP_UNUSED;
      end
      default: return 3'($urandom_range(7));
    endcase
  endfunction

  function automatic void check_field(string name, logic [VW-1:0] want, logic [VW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      items_in <= 0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        list_apply(op_code, operand_value);
        items_in <= items_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     (!pending_cmds[0].drain || (due_beats.size() == 0 && !out_valid))) begin
          in_valid <= 1'b1;
          op_code <= pending_cmds[0].op;
          operand_value <= pending_cmds[0].val;
          void'(pending_cmds.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && items_in >= 150) begin
      long_hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left <= 0) begin
        pattern_left <= $urandom_range(5, 60);
        pattern_mode <= $urandom_range(3);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (pattern_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(1));
        2: out_ready <= ($urandom_range(3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual status %0d item %0h",
                 $realtime, status, item_value, " end %0b count %0d", run_end, entry_count);
        errors++;
      end else begin
        got_beat = due_beats.pop_front();
        check_field("status", VW'(got_beat.st), VW'(status));
        check_field("item_value", got_beat.val, item_value);
        check_field("run_end", VW'(got_beat.fin), VW'(run_end));
        check_field("entry_count", VW'(got_beat.cnt), VW'(entry_count));
      end
    end
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rebuild_chain();

    add_cmd(cldq_pkg::OP_READ_OUT, 32'h0, 1'b0);
    add_cmd(cldq_pkg::OP_POP_FRONT, 32'h0, 1'b0);
    add_cmd(cldq_pkg::OP_POP_BACK, 32'h0, 1'b0);
    add_cmd(cldq_pkg::OP_DEL_AFTER, 32'h0, 1'b0);
    add_cmd(cldq_pkg::OP_CLEAR, 32'h0, 1'b0);
    add_cmd(OP_UNUSED, 32'hffff_ffff, 1'b0);
    add_cmd(cldq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
    add_cmd(cldq_pkg::OP_DEL_AFTER, 32'h7fff_ffff, 1'b0);
    add_cmd(cldq_pkg::OP_PUSH_BACK, 32'h8000_0000, 1'b0);
    add_cmd(cldq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 1'b0);
    add_cmd(cldq_pkg::OP_PUSH_BACK, 32'hffff_ffff, 1'b0);
    add_cmd(cldq_pkg::OP_READ_OUT, 32'h0, 1'b0);
    add_cmd(cldq_pkg::OP_DEL_AFTER, 32'h0000_0000, 1'b0);
    add_cmd(cldq_pkg::OP_DEL_AFTER, 32'h0000_0000, 1'b0);
    add_cmd(cldq_pkg::OP_DEL_AFTER, 32'h5555_5555, 1'b0);
    add_cmd(cldq_pkg::OP_PUSH_BACK, 32'haaaa_aaaa, 1'b0);
    add_cmd(cldq_pkg::OP_READ_OUT, 32'h0, 1'b0);
    add_cmd(cldq_pkg::OP_POP_BACK, 32'h0, 1'b0);
    add_cmd(cldq_pkg::OP_POP_FRONT, 32'h0, 1'b0);
    add_cmd(cldq_pkg::OP_PUSH_FRONT, 32'h0000_0001, 1'b0);
    add_cmd(cldq_pkg::OP_CLEAR, 32'h0, 1'b0);
    add_cmd(cldq_pkg::OP_READ_OUT, 32'h0, 1'b0);

    for (int k = 0; k < N_RANDOM; k++) begin
      add_cmd(pick_op((k / SEG_LEN) % 3), pick_value(),
              (k == 0) || (k == N_RANDOM / 2) ||
              ((k % SEG_LEN == 0) && ($urandom_range(2) == 0)));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (due_beats.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== circular_list_deque_engine_unit.f =====
sv/cldq_pkg.sv
sv/cldq_ctrl.sv
sv/cldq_datapath.sv
sv/circular_list_deque_engine_unit.sv
sim/circular_list_deque_engine_unit_test.sv
